### rtl/core/css_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// css_pkg
// Shared types and constants for the stylesheet comment stripper.
// ----------------------------------------------------------------------------
package css_pkg;

   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned QUEUE_DEPTH  = 4;

   localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_SQUOTE    = 8'h27;
   localparam logic [BYTE_W-1:0] CH_DQUOTE    = 8'h22;
   localparam logic [BYTE_W-1:0] CH_STAR      = 8'h2A;
   localparam logic [BYTE_W-1:0] CH_SLASH     = 8'h2F;
   localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;

   typedef enum logic [5:0] {
      MODE_NORMAL    = 6'b000001,
      MODE_SLASH     = 6'b000010,
      MODE_COMMENT   = 6'b000100,
      MODE_STAR      = 6'b001000,
      MODE_QUOTE     = 6'b010000,
      MODE_QUOTE_ESC = 6'b100000
   } scan_mode_type;

   // one result as it leaves the block
   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              byte_valid;
      logic              end_of_text;
   } result_type;

   // everything one request produces; the second result always carries a byte
   typedef struct packed {
      result_type        first;
      logic              has_second;
      logic [BYTE_W-1:0] second_byte;
      logic              second_eot;
   } entry_type;

   typedef struct packed {
      logic second_pending;
   } back_status_type;

endpackage

### rtl/core/css_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// css_front
// Scan state machine: classifies each request and builds its queue entry.
// ----------------------------------------------------------------------------
module css_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [css_pkg::BYTE_W-1:0] in_byte,
   input  logic                     is_last,
   output logic                     push,
   output css_pkg::entry_type       entry
);
   import css_pkg::*;

   scan_mode_type     mode_ff, mode_in;
   logic              dq_ff, dq_in;

   logic              nb_emit;
   scan_mode_type     nb_mode;
   logic              nb_dq;
   logic [1:0]        count;
   logic [BYTE_W-1:0] b0, b1;
   logic [BYTE_W-1:0] quote_char;

   // handling of a byte in normal text, shared with the slash-held flush
   always_comb begin
      nb_emit = 1'b1;
      nb_mode = MODE_NORMAL;
      nb_dq   = dq_ff;
      if (in_byte inside {CH_SQUOTE, CH_DQUOTE}) begin
         nb_mode = MODE_QUOTE;
         nb_dq   = (in_byte == CH_DQUOTE);
      end else if (in_byte == CH_SLASH && !is_last) begin
         nb_emit = 1'b0;
         nb_mode = MODE_SLASH;
      end
   end

   always_comb begin
      quote_char = dq_ff ? CH_DQUOTE : CH_SQUOTE;
      count      = 2'd0;
      b0         = in_byte;
      b1         = in_byte;
      mode_in    = mode_ff;
      dq_in      = dq_ff;
      case (mode_ff)
         MODE_SLASH: begin
            if (in_byte == CH_STAR) begin
               count   = 2'd1;
               b0      = CH_SPACE;
               mode_in = MODE_COMMENT;
            end else begin
               b0      = CH_SLASH;
               count   = nb_emit ? 2'd2 : 2'd1;
               mode_in = nb_mode;
               dq_in   = nb_dq;
            end
         end
         MODE_COMMENT: begin
            if (in_byte == CH_STAR) begin
               mode_in = MODE_STAR;
            end
         end
         MODE_STAR: begin
            if (in_byte == CH_SLASH) begin
               mode_in = MODE_NORMAL;
            end else if (in_byte != CH_STAR) begin
               mode_in = MODE_COMMENT;
            end
         end
         MODE_QUOTE: begin
            count = 2'd1;
            if (in_byte == CH_BACKSLASH && !is_last) begin
               mode_in = MODE_QUOTE_ESC;
            end else if (in_byte == quote_char) begin
               mode_in = MODE_NORMAL;
            end
         end
         MODE_QUOTE_ESC: begin
            count   = 2'd1;
            mode_in = MODE_QUOTE;
         end
         default: begin
            count   = nb_emit ? 2'd1 : 2'd0;
            mode_in = nb_mode;
            dq_in   = nb_dq;
         end
      endcase
      if (is_last) begin
         mode_in = MODE_NORMAL;
         dq_in   = 1'b0;
      end
   end

   always_comb begin
      push                    = accept && (count != 2'd0 || is_last);
      entry.first.out_byte    = (count == 2'd0) ? '0 : b0;
      entry.first.byte_valid  = (count != 2'd0);
      entry.first.end_of_text = is_last && (count != 2'd2);
      entry.has_second        = (count == 2'd2);
      entry.second_byte       = b1;
      entry.second_eot        = is_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         dq_ff   <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         dq_ff   <= dq_in;
      end
   end

endmodule

### rtl/core/css_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// css_queue
// Short register queue of entries between the scanner and the output side.
// ----------------------------------------------------------------------------
module css_queue #(
   parameter int unsigned DEPTH = css_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  css_pkg::entry_type push_entry,
   input  logic               pop,
   output css_pkg::entry_type head,
   output logic               empty,
   output logic               full
);
   import css_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   entry_type           slots_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   always_comb begin
      empty     = (count_ff == '0);
      full      = (count_ff == CNT_W'(DEPTH));
      head      = slots_ff[rd_ptr_ff];
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### rtl/core/css_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// css_back
// Output side: unpacks queue entries into single results, one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module css_back (
   input  logic                        clock,
   input  logic                        reset,
   input  css_pkg::entry_type          head,
   input  logic                        empty,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [css_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                        rsp_byte_valid,
   output logic                        rsp_end_of_text,
   output css_pkg::back_status_type    status
);
   import css_pkg::*;

   logic              valid_ff, valid_in;
   result_type        out_ff, out_in;
   logic              pend_ff, pend_in;
   logic [BYTE_W-1:0] pend_byte_ff, pend_byte_in;
   logic              pend_eot_ff, pend_eot_in;
   logic              load;

   always_comb begin
      load         = !valid_ff || rsp_ready;
      pop          = 1'b0;
      valid_in     = valid_ff;
      out_in       = out_ff;
      pend_in      = pend_ff;
      pend_byte_in = pend_byte_ff;
      pend_eot_in  = pend_eot_ff;
      if (load) begin
         if (pend_ff) begin
            valid_in           = 1'b1;
            out_in.out_byte    = pend_byte_ff;
            out_in.byte_valid  = 1'b1;
            out_in.end_of_text = pend_eot_ff;
            pend_in            = 1'b0;
         end else if (!empty) begin
            // second result of the entry waits in the pending slot until the output register can take it
            pop          = 1'b1;
            valid_in     = 1'b1;
            out_in       = head.first;
            pend_in      = head.has_second;
            pend_byte_in = head.second_byte;
            pend_eot_in  = head.second_eot;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff       <= out_in;
      pend_byte_ff <= pend_byte_in;
      pend_eot_ff  <= pend_eot_in;
   end

   assign rsp_valid             = valid_ff;
   assign rsp_out_byte          = out_ff.out_byte;
   assign rsp_byte_valid        = out_ff.byte_valid;
   assign rsp_end_of_text       = out_ff.end_of_text;
   assign status.second_pending = pend_ff;

endmodule

### rtl/core/css_comment_stripper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// css_comment_stripper
// Quote-aware slash-star comment stripper for stylesheet text.
// ----------------------------------------------------------------------------
//   channel   ports         direction   carries
//   request   req_*         in          one text byte and its last-byte flag
//   response  rsp_*         out         one cleaned byte or a bare end mark
//
// A request is accepted in any cycle the entry queue has room, one byte per
// clock. Each request is scanned in its accept cycle and yields zero, one or
// two responses; the output register sends one response per clock while
// rsp_ready is high, so a byte that flushes a held slash yields two responses,
// and the QUEUE_DEPTH-entry queue absorbs the extra one. Each response passes
// through a queue slot and then the output register.
// Synchronous reset returns the scanner to normal text and empties the queue.
// ----------------------------------------------------------------------------
module css_comment_stripper #(
   parameter int unsigned QUEUE_DEPTH = css_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [css_pkg::BYTE_W-1:0] req_in_byte,
   input  logic                       req_is_last,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [css_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                       rsp_byte_valid,
   output logic                       rsp_end_of_text
);
   import css_pkg::*;

   logic            accept;
   logic            push;
   entry_type       push_entry;
   entry_type       head;
   logic            empty;
   logic            full;
   logic            pop;
   back_status_type back_status;

   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   css_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_in_byte),
      .is_last (req_is_last),
      .push    (push),
      .entry   (push_entry)
   );

   css_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   css_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .empty           (empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_end_of_text (rsp_end_of_text),
      .status          (back_status)
   );

`ifndef ASSERT_OFF
   // a response without a byte is only ever the end mark
   a_bare_end_mark : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_end_of_text && rsp_out_byte == '0)
      else $error("bare response without end mark");

   // a held second result always sits behind a shown response
   a_pending_behind_out : assert property (@(posedge clock) disable iff (reset)
      back_status.second_pending |-> rsp_valid)
      else $error("pending result with empty output register");

   a_reset_clears_out : assert property (@(posedge clock)
      reset |=> !rsp_valid && !back_status.second_pending)
      else $error("output not cleared by reset");
`endif

endmodule
